@@ rtl/nearest_centroid_classifier_macros.svh @@
`ifndef NEAREST_CENTROID_CLASSIFIER_MACROS_SVH
`define NEAREST_CENTROID_CLASSIFIER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define NCC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ncc assertion failed");
`define NCC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ncc assertion failed");
`else
`define NCC_ASSERT_IMP(label, ante, cons)
`define NCC_ASSERT_NXT(label, ante, cons)
`endif

`endif

@@ rtl/ncc_pkg.sv @@
package ncc_pkg;

    localparam int TEMPLATES_DEF = 64;
    localparam int FEATURES_DEF  = 19;

    localparam int DV_NUM_W = 53;
    localparam int DV_DEN_W = 48;

    localparam logic [1:0] ACT_CLEAR    = 2'd0;
    localparam logic [1:0] ACT_SAMPLE   = 2'd1;
    localparam logic [1:0] ACT_CLASSIFY = 2'd2;

    localparam logic [2:0] ST_CLASSIFIED   = 3'd0;
    localparam logic [2:0] ST_NO_TEMPLATES = 3'd1;
    localparam logic [2:0] ST_ADDED        = 3'd2;
    localparam logic [2:0] ST_NO_SLOT      = 3'd3;
    localparam logic [2:0] ST_CLEARED      = 3'd4;

    localparam logic [6:0] CONF_SINGLE      = 7'd100;
    localparam logic [6:0] CONF_ZERO_SECOND = 7'd90;
    localparam logic [5:0] Q_MAX            = 6'd32;

    // 100*exp(-5*q/32)
    function automatic logic [6:0] conf_lut(input logic [5:0] q);
        logic [6:0] c;
        unique case (q)
            6'd0:  c = 7'd100;
            6'd1:  c = 7'd85;
            6'd2:  c = 7'd73;
            6'd3:  c = 7'd62;
            6'd4:  c = 7'd53;
            6'd5:  c = 7'd45;
            6'd6:  c = 7'd39;
            6'd7:  c = 7'd33;
            6'd8:  c = 7'd28;
            6'd9:  c = 7'd24;
            6'd10: c = 7'd20;
            6'd11: c = 7'd17;
            6'd12: c = 7'd15;
            6'd13: c = 7'd13;
            6'd14: c = 7'd11;
            6'd15: c = 7'd9;
            6'd16: c = 7'd8;
            6'd17: c = 7'd7;
            6'd18: c = 7'd6;
            6'd19: c = 7'd5;
            6'd20: c = 7'd4;
            6'd21: c = 7'd3;
            6'd22: c = 7'd3;
            6'd23: c = 7'd2;
            6'd24: c = 7'd2;
            6'd25: c = 7'd2;
            6'd26: c = 7'd1;
            6'd27: c = 7'd1;
            6'd28: c = 7'd1;
            6'd29: c = 7'd1;
            default: c = 7'd0;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/nearest_centroid_classifier.sv @@
// Nearest-centroid key classifier. Feature elements are written one per transaction while
// busy is low; the element marked last starts the work on the whole vector and busy stays
// high until the cycle in which the single result appears on the o_ result ports with
// o_valid. The receiver cannot stall, so a result must be taken in the cycle it appears.
// All divisions go through one shared restoring divider with a 53-bit numerator, and this
// divider sets the time per vector: a calibration sample searches the template slots and
// then updates the mean and variance of each feature (the first sample of a key only
// stores its features); a classify scans every template, sums a variance-scaled distance
// over the features of each active template, and then works out the confidence. A clear,
// and an element that is not last, leave busy low.
`include "nearest_centroid_classifier_macros.svh"

module nearest_centroid_classifier #(
    parameter int TEMPLATES = ncc_pkg::TEMPLATES_DEF,
    parameter int FEATURES  = ncc_pkg::FEATURES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_action,
    input  logic [7:0]         i_key_code,
    input  logic [4:0]         i_feature_index,
    input  logic signed [15:0] i_feature_value,
    input  logic               i_last,
    output logic               o_valid,
    output logic [7:0]         o_result_key,
    output logic [6:0]         o_confidence,
    output logic [2:0]         o_status
);

    localparam int SW = $clog2(TEMPLATES);
    localparam int FW = (FEATURES > 1) ? $clog2(FEATURES) : 1;
    localparam int AW = $clog2(TEMPLATES * FEATURES);
    localparam int NW = ncc_pkg::DV_NUM_W;
    localparam int DW = ncc_pkg::DV_DEN_W;
    localparam int CW = $clog2(NW);

    typedef enum logic [17:0] {
        S_IDLE     = 18'b000000000000000001,
        S_FIND_RD  = 18'b000000000000000010,
        S_FIND_CHK = 18'b000000000000000100,
        S_A_RD     = 18'b000000000000001000,
        S_A_D1     = 18'b000000000000010000,
        S_A_W1     = 18'b000000000000100000,
        S_A_M2     = 18'b000000000001000000,
        S_A_SUM    = 18'b000000000010000000,
        S_A_W2     = 18'b000000000100000000,
        S_C_SLOT   = 18'b000000001000000000,
        S_C_RD     = 18'b000000010000000000,
        S_C_MUL    = 18'b000000100000000000,
        S_C_DIV    = 18'b000001000000000000,
        S_C_WAIT   = 18'b000010000000000000,
        S_C_UPD    = 18'b000100000000000000,
        S_C_END    = 18'b001000000000000000,
        S_C_KEY    = 18'b010000000000000000,
        S_C_QW     = 18'b100000000000000000
    } t_state;

    t_state              r_state;
    logic [SW-1:0]       r_slot, r_best, r_free_slot;
    logic                r_free_found;
    logic [AW-1:0]       r_addr, r_base, r_free_base;
    logic [FW-1:0]       r_f;
    logic [TEMPLATES-1:0] r_vld;
    logic signed [15:0]  r_buf [FEATURES];
    logic [7:0]          r_keyin;
    logic [15:0]         r_n;

    logic [7:0]          r_key_mem  [TEMPLATES];
    logic [15:0]         r_samp_mem [TEMPLATES];
    logic signed [15:0]  r_mean_mem [TEMPLATES * FEATURES];
    logic [31:0]         r_var_mem  [TEMPLATES * FEATURES];
    logic [7:0]          r_key_q;
    logic [15:0]         r_samp_q;
    logic signed [15:0]  r_mean_q;
    logic [31:0]         r_var_q;

    logic signed [16:0]  r_delta;
    logic signed [15:0]  r_nm;
    logic [47:0]         r_acc;
    logic signed [50:0]  r_mul;
    logic [31:0]         r_vf;
    logic [47:0]         r_dist, r_bestd, r_second;
    logic                r_have_best, r_have_second;

    logic                r_dv_run;
    logic [CW-1:0]       r_dv_cnt;
    logic [NW-1:0]       r_dv_num;
    logic [DW-1:0]       r_dv_rem, r_dv_den;

    logic                r_valid;
    logic [7:0]          r_okey;
    logic [6:0]          r_oconf;
    logic [2:0]          r_ostat;

    logic signed [15:0]  x;
    logic signed [16:0]  delta, delta2, diff;
    logic [16:0]         abs_delta;
    logic signed [15:0]  nm;
    logic [48:0]         acc49, dsum;
    logic signed [32:0]  mul_a;
    logic signed [17:0]  mul_b;
    logic                dv_go;
    logic [NW-1:0]       dv_num_in;
    logic [DW-1:0]       dv_den_in;
    logic [DW:0]         dv_t, dv_sub;
    logic                dv_ge;
    logic                hit, take, key_we, samp_we, mem_we;
    logic [SW-1:0]       take_slot;
    logic [AW-1:0]       take_base;
    logic signed [15:0]  mem_wm;
    logic [31:0]         mem_wv;
    logic [5:0]          qc;
    logic                last_slot, last_feat;
    logic [FW-1:0]       wr_idx;

    assign x         = r_buf[r_f];
    assign delta     = {x[15], x} - {r_mean_q[15], r_mean_q};
    assign diff      = delta;
    assign abs_delta = delta[16] ? 17'(-delta) : delta;
    assign delta2    = {x[15], x} - {r_nm[15], r_nm};
    assign nm        = r_delta[16] ? r_mean_q - $signed(r_dv_num[15:0])
                                   : r_mean_q + $signed(r_dv_num[15:0]);
    assign acc49     = {1'b0, r_acc} + (r_mul[50] ? 49'd0 : r_mul[48:0]);
    assign dsum      = {1'b0, r_dist} + {1'b0, r_dv_num[47:0]};
    assign qc        = (r_dv_num > NW'(ncc_pkg::Q_MAX)) ? ncc_pkg::Q_MAX : r_dv_num[5:0];
    assign last_slot = (r_slot == SW'(TEMPLATES - 1));
    assign last_feat = (r_f == FW'(FEATURES - 1));
    assign wr_idx    = FW'(i_feature_index);

    assign hit       = r_vld[r_slot] && (r_key_q == r_keyin);
    assign take      = r_free_found || !r_vld[r_slot];
    assign take_slot = r_free_found ? r_free_slot : r_slot;
    assign take_base = r_free_found ? r_free_base : r_base;
    assign key_we    = (r_state == S_FIND_CHK) && !hit && last_slot && take;

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_A_D1 || r_state == S_A_W1) begin
            mul_a = $signed({1'b0, r_var_q});
            mul_b = $signed({2'b00, r_n - 16'd2});
        end else if (r_state == S_A_M2) begin
            mul_a = {{16{r_delta[16]}}, r_delta};
            mul_b = {delta2[16], delta2};
        end else if (r_state == S_C_MUL) begin
            mul_a = {{16{diff[16]}}, diff};
            mul_b = {diff[16], diff};
        end
    end

    // shared divider launch
    always_comb begin
        dv_go     = 1'b0;
        dv_num_in = '0;
        dv_den_in = '0;
        if (r_state == S_A_D1 && r_n != 16'd1) begin
            dv_go     = 1'b1;
            dv_num_in = NW'(abs_delta);
            dv_den_in = DW'(r_n);
        end else if (r_state == S_A_SUM) begin
            dv_go     = 1'b1;
            dv_num_in = NW'(acc49);
            dv_den_in = DW'(r_n - 16'd1);
        end else if (r_state == S_C_DIV) begin
            dv_go     = 1'b1;
            dv_num_in = NW'({r_mul[31:0], 16'd0});
            dv_den_in = DW'(r_vf);
        end else if (r_state == S_C_KEY && r_have_best && r_have_second && r_second != '0) begin
            dv_go     = 1'b1;
            dv_num_in = NW'({r_bestd, 5'd0});
            dv_den_in = r_second;
        end
    end

    assign dv_t   = {r_dv_rem, r_dv_num[NW-1]};
    assign dv_ge  = (dv_t >= {1'b0, r_dv_den});
    assign dv_sub = dv_t - {1'b0, r_dv_den};

    // template entry write
    always_comb begin
        mem_we = 1'b0;
        mem_wm = x;
        mem_wv = '0;
        if (r_state == S_A_D1 && r_n == 16'd1) begin
            mem_we = 1'b1;
        end else if (r_state == S_A_W2 && !r_dv_run) begin
            mem_we = 1'b1;
            mem_wm = r_nm;
            mem_wv = (|r_dv_num[NW-1:32]) ? 32'hFFFF_FFFF : r_dv_num[31:0];
        end
    end

    assign samp_we = mem_we && last_feat;

    always_ff @(posedge i_clk) begin
        r_key_q  <= r_key_mem[r_slot];
        r_samp_q <= r_samp_mem[r_slot];
        r_mean_q <= r_mean_mem[r_addr];
        r_var_q  <= r_var_mem[r_addr];
        if (key_we) begin
            r_key_mem[take_slot] <= r_keyin;
        end
        if (samp_we) begin
            r_samp_mem[r_slot] <= r_n;
        end
        if (mem_we) begin
            r_mean_mem[r_addr] <= mem_wm;
            r_var_mem[r_addr]  <= mem_wv;
        end
        r_mul <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_vld         <= '0;
            r_valid       <= 1'b0;
            r_dv_run      <= 1'b0;
            r_free_found  <= 1'b0;
            r_have_best   <= 1'b0;
            r_have_second <= 1'b0;
            for (int i = 0; i < FEATURES; i++) begin
                r_buf[i] <= '0;
            end
        end else begin
            r_valid <= 1'b0;

            if (dv_go) begin
                r_dv_num <= dv_num_in;
                r_dv_den <= dv_den_in;
                r_dv_rem <= '0;
                r_dv_cnt <= CW'(NW - 1);
                r_dv_run <= 1'b1;
            end else if (r_dv_run) begin
                r_dv_rem <= dv_ge ? dv_sub[DW-1:0] : dv_t[DW-1:0];
                r_dv_num <= {r_dv_num[NW-2:0], dv_ge};
                if (r_dv_cnt == '0) begin
                    r_dv_run <= 1'b0;
                end else begin
                    r_dv_cnt <= r_dv_cnt - CW'(1);
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        if (i_action == ncc_pkg::ACT_CLEAR) begin
                            r_vld   <= '0;
                            r_valid <= 1'b1;
                            r_okey  <= '0;
                            r_oconf <= '0;
                            r_ostat <= ncc_pkg::ST_CLEARED;
                        end else if (i_action == ncc_pkg::ACT_SAMPLE ||
                                     i_action == ncc_pkg::ACT_CLASSIFY) begin
                            if (int'(i_feature_index) < FEATURES) begin
                                r_buf[wr_idx] <= i_feature_value;
                            end
                            r_keyin       <= i_key_code;
                            r_slot        <= '0;
                            r_base        <= '0;
                            r_addr        <= '0;
                            r_free_found  <= 1'b0;
                            r_have_best   <= 1'b0;
                            r_have_second <= 1'b0;
                            if (i_last) begin
                                r_state <= (i_action == ncc_pkg::ACT_SAMPLE) ? S_FIND_RD
                                                                             : S_C_SLOT;
                            end
                        end
                    end
                end
                S_FIND_RD: r_state <= S_FIND_CHK;
                S_FIND_CHK: begin
                    if (hit) begin
                        r_n     <= (r_samp_q == 16'hFFFF) ? 16'hFFFF : r_samp_q + 16'd1;
                        r_addr  <= r_base;
                        r_f     <= '0;
                        r_state <= S_A_RD;
                    end else if (last_slot) begin
                        if (take) begin
                            r_vld[take_slot] <= 1'b1;
                            r_slot  <= take_slot;
                            r_addr  <= take_base;
                            r_n     <= 16'd1;
                            r_f     <= '0;
                            r_state <= S_A_RD;
                        end else begin
                            r_valid <= 1'b1;
                            r_okey  <= r_keyin;
                            r_oconf <= '0;
                            r_ostat <= ncc_pkg::ST_NO_SLOT;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        if (!r_vld[r_slot] && !r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free_slot  <= r_slot;
                            r_free_base  <= r_base;
                        end
                        r_slot  <= r_slot + SW'(1);
                        r_base  <= r_base + AW'(FEATURES);
                        r_state <= S_FIND_RD;
                    end
                end
                S_A_RD: r_state <= S_A_D1;
                S_A_D1: begin
                    if (r_n != 16'd1) begin
                        r_delta <= delta;
                        r_state <= S_A_W1;
                    end
                end
                S_A_W1: begin
                    if (!r_dv_run) begin
                        r_nm    <= nm;
                        r_acc   <= r_mul[47:0];
                        r_state <= S_A_M2;
                    end
                end
                S_A_M2:  r_state <= S_A_SUM;
                S_A_SUM: r_state <= S_A_W2;
                S_A_W2: begin
                end
                S_C_SLOT: begin
                    if (r_vld[r_slot]) begin
                        r_f     <= '0;
                        r_dist  <= '0;
                        r_state <= S_C_RD;
                    end else if (last_slot) begin
                        r_slot  <= r_best;
                        r_state <= S_C_END;
                    end else begin
                        r_slot <= r_slot + SW'(1);
                        r_addr <= r_addr + AW'(FEATURES);
                    end
                end
                S_C_RD: r_state <= S_C_MUL;
                S_C_MUL: begin
                    r_vf    <= (r_var_q == '0) ? 32'd1 : r_var_q;
                    r_state <= S_C_DIV;
                end
                S_C_DIV: r_state <= S_C_WAIT;
                S_C_WAIT: begin
                    if (!r_dv_run) begin
                        r_dist <= dsum[48] ? '1 : dsum[47:0];
                        r_addr <= r_addr + AW'(1);
                        if (last_feat) begin
                            r_state <= S_C_UPD;
                        end else begin
                            r_f     <= r_f + FW'(1);
                            r_state <= S_C_RD;
                        end
                    end
                end
                S_C_UPD: begin
                    if (!r_have_best || r_dist < r_bestd) begin
                        r_second      <= r_bestd;
                        r_have_second <= r_have_best;
                        r_bestd       <= r_dist;
                        r_have_best   <= 1'b1;
                        r_best        <= r_slot;
                    end else if (!r_have_second || r_dist < r_second) begin
                        r_second      <= r_dist;
                        r_have_second <= 1'b1;
                    end
                    if (last_slot) begin
                        // point the key read at the winner before the result cycle
                        if (r_have_best && !(r_dist < r_bestd)) begin
                            r_slot <= r_best;
                        end
                        r_state <= S_C_END;
                    end else begin
                        r_slot  <= r_slot + SW'(1);
                        r_state <= S_C_SLOT;
                    end
                end
                S_C_END: begin
                    r_slot  <= r_best;
                    r_state <= S_C_KEY;
                end
                S_C_KEY: begin
                    priority if (!r_have_best) begin
                        r_valid <= 1'b1;
                        r_okey  <= '0;
                        r_oconf <= '0;
                        r_ostat <= ncc_pkg::ST_NO_TEMPLATES;
                        r_state <= S_IDLE;
                    end else if (!r_have_second) begin
                        r_valid <= 1'b1;
                        r_okey  <= r_key_q;
                        r_oconf <= ncc_pkg::CONF_SINGLE;
                        r_ostat <= ncc_pkg::ST_CLASSIFIED;
                        r_state <= S_IDLE;
                    end else if (r_second == '0) begin
                        r_valid <= 1'b1;
                        r_okey  <= r_key_q;
                        r_oconf <= ncc_pkg::CONF_ZERO_SECOND;
                        r_ostat <= ncc_pkg::ST_CLASSIFIED;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_C_QW;
                    end
                end
                S_C_QW: begin
                    if (!r_dv_run) begin
                        r_valid <= 1'b1;
                        r_okey  <= r_key_q;
                        r_oconf <= ncc_pkg::conf_lut(qc);
                        r_ostat <= ncc_pkg::ST_CLASSIFIED;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            // one feature of a template written back
            if (mem_we) begin
                if (last_feat) begin
                    r_valid <= 1'b1;
                    r_okey  <= r_keyin;
                    r_oconf <= '0;
                    r_ostat <= ncc_pkg::ST_ADDED;
                    r_state <= S_IDLE;
                end else begin
                    r_f     <= r_f + FW'(1);
                    r_addr  <= r_addr + AW'(1);
                    r_state <= S_A_RD;
                end
            end
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_result_key = r_okey;
    assign o_confidence = r_oconf;
    assign o_status     = r_ostat;

    `NCC_ASSERT_IMP(a_conf_range, o_valid, o_confidence <= 7'd100)
    `NCC_ASSERT_IMP(a_conf_zero, o_valid && o_status != ncc_pkg::ST_CLASSIFIED, o_confidence == 7'd0)
    `NCC_ASSERT_NXT(a_clear_ack, start && !busy && i_action == ncc_pkg::ACT_CLEAR, o_valid && o_status == ncc_pkg::ST_CLEARED)
    `NCC_ASSERT_IMP(a_div_wait, r_dv_run, r_state == S_A_W1 || r_state == S_A_W2 || r_state == S_C_WAIT || r_state == S_C_QW)

endmodule

@@ test/nearest_centroid_classifier_test.sv @@
module nearest_centroid_classifier_test;

    localparam int NSLOT = 64;
    localparam int NFEAT = 19;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam longint SUM_MAX = (longint'(1) << 48) - 1;
    localparam int WATCHDOG_LIMIT = 400000;
    localparam byte unsigned CONF_CURVE [0:32] = '{
        100, 85, 73, 62, 53, 45, 39, 33, 28, 24, 20, 17, 15, 13, 11, 9,
        8, 7, 6, 5, 4, 3, 3, 2, 2, 2, 1, 1, 1, 1, 0, 0, 0
    };

    typedef struct {
        logic [1:0]         action;
        logic [7:0]         key;
        logic [4:0]         index;
        logic signed [15:0] value;
        logic               last;
    } t_element;

    typedef struct {
        logic [7:0] key;
        logic [6:0] conf;
        logic [2:0] status;
    } t_verdict;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_action = '0;
    logic [7:0]         i_key_code = '0;
    logic [4:0]         i_feature_index = '0;
    logic signed [15:0] i_feature_value = '0;
    logic               i_last = 1'b0;
    logic               o_valid;
    logic [7:0]         o_result_key;
    logic [6:0]         o_confidence;
    logic [2:0]         o_status;

    t_element pending_elements[$];
    t_verdict expected_verdicts[$];
    int errors = 0;
    int elements_sent = 0;
    int total_elements = 0;
    int idle_cycles = 0;
    int status_seen [0:7];

    // predictor state
    logic signed [15:0] feat_buf [NFEAT];
    bit                 tmpl_valid [NSLOT];
    logic [7:0]         tmpl_key [NSLOT];
    logic signed [15:0] tmpl_mean [NSLOT][NFEAT];
    logic [31:0]        tmpl_var [NSLOT][NFEAT];
    logic [15:0]        tmpl_count [NSLOT];

    nearest_centroid_classifier dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_action(i_action), .i_key_code(i_key_code), .i_feature_index(i_feature_index),
        .i_feature_value(i_feature_value), .i_last(i_last), .o_valid(o_valid),
        .o_result_key(o_result_key), .o_confidence(o_confidence), .o_status(o_status)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [2:0] learn_sample(input logic [7:0] key);
        int slot;
        longint n, x, old, delta, nm, prod, acc, v;
        slot = -1;
        for (int s = 0; s < NSLOT; s++)
            if (slot < 0 && tmpl_valid[s] && tmpl_key[s] == key) slot = s;
        for (int s = 0; s < NSLOT; s++) begin
            if (slot < 0 && !tmpl_valid[s]) begin
                slot = s;
                tmpl_valid[s] = 1'b1;
                tmpl_key[s] = key;
                tmpl_count[s] = '0;
            end
        end
        if (slot < 0) return ncc_pkg::ST_NO_SLOT;
        n = longint'(tmpl_count[slot]) + 1;
        if (n > 65535) n = 65535;
        for (int f = 0; f < NFEAT; f++) begin
            x = feat_buf[f];
            if (n == 1) begin
                tmpl_mean[slot][f] = feat_buf[f];
                tmpl_var[slot][f] = '0;
            end else begin
                old = tmpl_mean[slot][f];
                delta = x - old;
                nm = old + delta / n;
                prod = delta * (x - nm);
                if (prod < 0) prod = 0;
                acc = (n - 2) * longint'(tmpl_var[slot][f]) + prod;
                v = acc / (n - 1);
                if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
                tmpl_mean[slot][f] = nm[15:0];
                tmpl_var[slot][f] = v[31:0];
            end
        end
        tmpl_count[slot] = n[15:0];
        return ncc_pkg::ST_ADDED;
    endfunction

    function automatic t_verdict nearest_template();
        t_verdict r;
        bit have_best, have_second;
        longint best, second, total, diff, den, term, q;
        int best_slot;
        have_best = 0;
        have_second = 0;
        best = 0;
        second = 0;
        best_slot = 0;
        for (int s = 0; s < NSLOT; s++) begin
            if (tmpl_valid[s]) begin
                total = 0;
                for (int f = 0; f < NFEAT; f++) begin
                    diff = longint'(feat_buf[f]) - longint'(tmpl_mean[s][f]);
                    den = tmpl_var[s][f];
                    if (den < 1) den = 1;
                    term = ((diff * diff) << 16) / den;
                    if (term > SUM_MAX) term = SUM_MAX;
                    total += term;
                    if (total > SUM_MAX) total = SUM_MAX;
                end
                if (!have_best || total < best) begin
                    second = best;
                    have_second = have_best;
                    best = total;
                    have_best = 1;
                    best_slot = s;
                end else if (!have_second || total < second) begin
                    second = total;
                    have_second = 1;
                end
            end
        end
        if (!have_best) begin
            r = '{8'd0, 7'd0, ncc_pkg::ST_NO_TEMPLATES};
        end else begin
            r.key = tmpl_key[best_slot];
            r.status = ncc_pkg::ST_CLASSIFIED;
            if (!have_second) begin
                r.conf = ncc_pkg::CONF_SINGLE;
            end else if (second == 0) begin
                r.conf = ncc_pkg::CONF_ZERO_SECOND;
            end else begin
                q = (best << 5) / second;
                if (q > 32) q = 32;
                r.conf = CONF_CURVE[q];
            end
        end
        return r;
    endfunction

    task automatic predict_element(input t_element e);
        if (e.action == ncc_pkg::ACT_CLEAR) begin
            for (int s = 0; s < NSLOT; s++) begin
                tmpl_valid[s] = 0;
                tmpl_count[s] = '0;
            end
            expected_verdicts.push_back('{8'd0, 7'd0, ncc_pkg::ST_CLEARED});
        end else if (e.action != ACT_UNUSED) begin
            if (e.index < NFEAT) feat_buf[e.index] = e.value;
            if (e.last) begin
                if (e.action == ncc_pkg::ACT_SAMPLE)
                    expected_verdicts.push_back('{e.key, 7'd0, learn_sample(e.key)});
                else
                    expected_verdicts.push_back(nearest_template());
            end
        end
    endtask

    task automatic report(input string what, input int got, input int want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    task automatic queue_element(input logic [1:0] a, input logic [7:0] k, input logic [4:0] idx,
                                 input logic [15:0] v, input logic l);
        pending_elements.push_back('{a, k, idx, v, l});
    endtask

    function automatic logic [15:0] random_feature();
        case ($urandom_range(3))
            0: return 16'(32'h7FFF + $urandom_range(3));
            1: return 16'($urandom_range(65535));
            default: return 16'($urandom_range(1024) - 512);
        endcase
    endfunction

    task automatic queue_vector(input logic [1:0] a, input logic [7:0] k);
        int len;
        len = ($urandom_range(9) == 0) ? NFEAT : $urandom_range(1, 4);
        for (int i = 0; i < len; i++)
            queue_element(a, k, (len == NFEAT) ? 5'(i) : 5'($urandom_range(NFEAT - 1)),
                          random_feature(), i == len - 1);
    endtask

    // driver
    always @(posedge i_clk) begin
        int idle_pct;
        t_element e;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                elements_sent++;
                predict_element('{i_action, i_key_code, i_feature_index, i_feature_value,
                                  i_last});
            end
            if (!(start && busy)) begin
                idle_pct = (elements_sent < total_elements / 3) ? 23 :
                           (elements_sent < 2 * total_elements / 3) ? 70 : 0;
                if (pending_elements.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    e = pending_elements.pop_front();
                    i_action <= e.action;
                    i_key_code <= e.key;
                    i_feature_index <= e.index;
                    i_feature_value <= e.value;
                    i_last <= e.last;
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_verdict w;
        if (i_rst_n && o_valid) begin
            if (expected_verdicts.size() == 0) begin
                report("unexpected transaction status", o_status, -1);
            end else begin
                w = expected_verdicts.pop_front();
                status_seen[w.status]++;
                if (o_status !== w.status) report("status", o_status, w.status);
                if (o_result_key !== w.key) report("result_key", o_result_key, w.key);
                if (o_confidence !== w.conf) report("confidence", o_confidence, w.conf);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d quiet cycles", idle_cycles);
            $display("FAIL nearest_centroid_classifier");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [7:0] key_pool [5];
        int r;
        foreach (status_seen[i]) status_seen[i] = 0;
        for (int f = 0; f < NFEAT; f++) feat_buf[f] = '0;
        for (int s = 0; s < NSLOT; s++) begin
            tmpl_valid[s] = 0;
            tmpl_key[s] = '0;
            tmpl_count[s] = '0;
            for (int f = 0; f < NFEAT; f++) begin
                tmpl_mean[s][f] = '0;
                tmpl_var[s][f] = '0;
            end
        end

        // directed: empty set, extremes, out of range index, single template, ties
        queue_element(ncc_pkg::ACT_CLEAR, 8'hA5, 5'd31, 16'hFFFF, 1'b0);
        queue_element(ncc_pkg::ACT_CLASSIFY, 8'h00, 5'd0, 16'h7FFF, 1'b1);
        queue_element(ACT_UNUSED, 8'hFF, 5'd31, 16'h8000, 1'b1);
        queue_element(ncc_pkg::ACT_SAMPLE, 8'hFF, 5'd18, 16'h8000, 1'b0);
        queue_element(ncc_pkg::ACT_SAMPLE, 8'hFF, 5'd31, 16'h1234, 1'b1);
        queue_element(ncc_pkg::ACT_CLASSIFY, 8'h00, 5'd0, 16'h0000, 1'b1);
        queue_element(ncc_pkg::ACT_SAMPLE, 8'h00, 5'd0, 16'h0000, 1'b1);
        queue_element(ncc_pkg::ACT_SAMPLE, 8'h00, 5'd0, 16'h0100, 1'b1);
        queue_element(ncc_pkg::ACT_SAMPLE, 8'hFF, 5'd5, 16'h7FFF, 1'b1);
        queue_element(ncc_pkg::ACT_CLASSIFY, 8'h00, 5'd3, 16'hFFFF, 1'b1);
        queue_element(ncc_pkg::ACT_CLEAR, 8'h00, 5'd0, 16'h0000, 1'b1);
        queue_element(ncc_pkg::ACT_SAMPLE, 8'h07, 5'd0, 16'h0064, 1'b1);
        queue_element(ncc_pkg::ACT_SAMPLE, 8'h09, 5'd0, 16'h0064, 1'b1);
        queue_element(ncc_pkg::ACT_CLASSIFY, 8'h00, 5'd0, 16'h0064, 1'b1);
        queue_element(ncc_pkg::ACT_CLASSIFY, 8'h00, 5'd0, 16'h8000, 1'b1);

        // fill every template, then one more key
        queue_element(ncc_pkg::ACT_CLEAR, 8'h00, 5'd0, 16'h0000, 1'b0);
        for (int s = 0; s < NSLOT; s++)
            queue_element(ncc_pkg::ACT_SAMPLE, 8'(s), 5'($urandom_range(NFEAT - 1)),
                          random_feature(), 1'b1);
        queue_element(ncc_pkg::ACT_SAMPLE, 8'd200, 5'd1, 16'h0010, 1'b1);
        queue_element(ncc_pkg::ACT_CLASSIFY, 8'h00, 5'd2, random_feature(), 1'b1);
        queue_element(ncc_pkg::ACT_CLEAR, 8'h00, 5'd0, 16'h0000, 1'b0);

        foreach (key_pool[i]) key_pool[i] = 8'($urandom_range(255));
        while (pending_elements.size() < 290) begin
            r = $urandom_range(99);
            if (r < 6) begin
                queue_element(ncc_pkg::ACT_CLEAR, 8'($urandom_range(255)),
                              5'($urandom_range(31)), 16'($urandom_range(65535)),
                              1'($urandom_range(1)));
                foreach (key_pool[i]) key_pool[i] = 8'($urandom_range(255));
            end else if (r < 12) begin
                queue_element(r < 9 ? ACT_UNUSED : 2'($urandom_range(1, 2)),
                              8'($urandom_range(255)), 5'($urandom_range(NFEAT, 31)),
                              16'($urandom_range(65535)), 1'($urandom_range(1)));
            end else if (r < 62) begin
                queue_vector(ncc_pkg::ACT_SAMPLE, key_pool[$urandom_range(4)]);
            end else begin
                queue_vector(ncc_pkg::ACT_CLASSIFY, 8'($urandom_range(255)));
            end
        end
        total_elements = pending_elements.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_elements.size() > 0 || start) @(posedge i_clk);
        while (expected_verdicts.size() > 0 || busy) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("sent %0d elements: %0d classified, %0d empty, %0d added, %0d no slot",
                 elements_sent, status_seen[ncc_pkg::ST_CLASSIFIED],
                 status_seen[ncc_pkg::ST_NO_TEMPLATES], status_seen[ncc_pkg::ST_ADDED],
                 status_seen[ncc_pkg::ST_NO_SLOT]);
        $display("%0d clears, all 64 templates filled once, %0d mismatches",
                 status_seen[ncc_pkg::ST_CLEARED], errors);
        if (errors == 0 && expected_verdicts.size() == 0) begin
            $display("PASS nearest_centroid_classifier");
        end else begin
            $display("FAIL nearest_centroid_classifier");
        end
        $finish;
    end
endmodule

@@ nearest_centroid_classifier.f @@
+incdir+rtl
rtl/ncc_pkg.sv
rtl/nearest_centroid_classifier.sv
test/nearest_centroid_classifier_test.sv
